@@ rtl/core/mf3_pkg.sv @@
// Shared constants, types and register codes of the 3x3 RGB median filter.
package mf3_pkg;

  // Channel and pixel widths; a pixel is blue in the low byte, red in the high byte
  localparam int unsigned CH_W  = 8;
  localparam int unsigned N_CH  = 3;
  localparam int unsigned PIX_W = CH_W * N_CH;

  // Frame size limits
  localparam int unsigned MAX_WIDTH  = 2048;
  localparam int unsigned MAX_HEIGHT = 4095;
  localparam int unsigned COL_W      = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W      = $clog2(MAX_HEIGHT + 1);

  // Configuration registers
  localparam int unsigned CFG_W  = 12;
  localparam int unsigned IDX_W  = 1;
  localparam int unsigned WID_W  = (CFG_W > COL_W + 1) ? CFG_W : COL_W + 1;
  localparam int unsigned HGT_W  = (CFG_W > ROW_W) ? CFG_W : ROW_W;
  localparam logic [CFG_W-1:0] IMAGE_WIDTH_RESET  = CFG_W'(640);
  localparam logic [CFG_W-1:0] IMAGE_HEIGHT_RESET = CFG_W'(480);

  typedef enum logic [IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } mf3_reg_e;

  // Stream widths
  localparam int unsigned IN_TDATA_W  = ((PIX_W + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = ((PIX_W + ROW_W + COL_W + 7) / 8) * 8;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } mf3_pix_t;

  // Per-pixel bookkeeping that travels with the pixel down the pipeline
  typedef struct packed {
    logic             emit;
    logic             last;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } mf3_meta_t;

  typedef struct packed {
    logic             last;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    mf3_pix_t         med;
  } mf3_res_t;

endpackage

@@ rtl/core/mf3_raster.sv @@
// Configuration registers and raster row/column tracking of the median filter.
module mf3_raster import mf3_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  logic             accept_i,
  output logic [COL_W-1:0] rd_addr_o,
  output mf3_meta_t        meta_o
);

  logic [CFG_W-1:0] width_q, height_q;
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;

  logic [WID_W-1:0] w, c_inc;
  logic [HGT_W-1:0] h, r_pre, r_inc;
  logic             col_wrap;
  logic [COL_W-1:0] c0;
  logic [ROW_W-1:0] r0;

  // Config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= IMAGE_WIDTH_RESET;
      height_q <= IMAGE_HEIGHT_RESET;
    end else if (cfg_we_i) begin
      unique case (mf3_reg_e'(cfg_idx_i))
        REG_IMAGE_WIDTH:  width_q  <= cfg_wdata_i;
        REG_IMAGE_HEIGHT: height_q <= cfg_wdata_i;
        default:          width_q  <= width_q;
      endcase
    end
  end

  // Clamp the frame size into the supported range
  always_comb begin
    if (width_q == '0) begin
      w = WID_W'(1);
    end else if (WID_W'(width_q) > WID_W'(MAX_WIDTH)) begin
      w = WID_W'(MAX_WIDTH);
    end else begin
      w = WID_W'(width_q);
    end
    if (height_q == '0) begin
      h = HGT_W'(1);
    end else if (HGT_W'(height_q) > HGT_W'(MAX_HEIGHT)) begin
      h = HGT_W'(MAX_HEIGHT);
    end else begin
      h = HGT_W'(height_q);
    end
  end

  // Position of this pixel; counters may sit past a bound after a resize
  always_comb begin
    col_wrap = WID_W'(col_q) >= w;
    c0       = col_wrap ? '0 : col_q;
    r_pre    = col_wrap ? HGT_W'(row_q) + HGT_W'(1) : HGT_W'(row_q);
    r0       = (r_pre >= h) ? '0 : ROW_W'(r_pre);
  end

  // Advance to the next pixel
  always_comb begin
    c_inc = WID_W'(c0) + WID_W'(1);
    r_inc = HGT_W'(r0) + HGT_W'(1);
    if (c_inc >= w) begin
      col_d = '0;
      row_d = (r_inc >= h) ? '0 : ROW_W'(r_inc);
    end else begin
      col_d = COL_W'(c_inc);
      row_d = r0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept_i) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Interior pixels emit a result centered one row up and one column left
  always_comb begin
    rd_addr_o   = c0;
    meta_o.emit = (r0 >= ROW_W'(2)) && (c0 >= COL_W'(2));
    meta_o.last = (HGT_W'(r0) == h - HGT_W'(1)) && (WID_W'(c0) == w - WID_W'(1));
    meta_o.row  = r0 - ROW_W'(1);
    meta_o.col  = c0 - COL_W'(1);
  end

endmodule

@@ rtl/core/mf3_line_store.sv @@
// Two-row line memory with read-modify-write and same-entry forwarding.
module mf3_line_store import mf3_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             rd_en_i,
  input  logic [COL_W-1:0] rd_addr_i,
  input  mf3_pix_t         pix_i,
  input  mf3_meta_t        meta_i,
  output logic             valid_o,
  output mf3_pix_t         pix_o,
  output mf3_pix_t         up_o,
  output mf3_pix_t         mid_o,
  output mf3_meta_t        meta_o
);

  // Entry holds {middle row, upper row} of one column
  logic [2*PIX_W-1:0] mem_q [MAX_WIDTH];
  logic [2*PIX_W-1:0] rdata_q, fwd_data_q, entry;
  logic               valid_q, fwd_q, wr_en, fwd_hit;
  logic [COL_W-1:0]   addr_q;
  mf3_pix_t           pix_q;
  mf3_meta_t          meta_q;

  assign wr_en   = en_i && valid_q;
  assign fwd_hit = wr_en && (addr_q == rd_addr_i);

  // Data seen by the held beat: the write of the same edge wins over the memory
  assign entry = fwd_q ? fwd_data_q : rdata_q;
  assign up_o  = mf3_pix_t'(entry[PIX_W-1:0]);
  assign mid_o = mf3_pix_t'(entry[2*PIX_W-1:PIX_W]);

  // Memory port: read on accept, write back when the held beat moves on
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[addr_q] <= {pix_q, mid_o};
    end
    if (rd_en_i) begin
      rdata_q <= mem_q[rd_addr_i];
    end
  end

  // Stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      fwd_q   <= 1'b0;
    end else begin
      if (en_i) begin
        valid_q <= rd_en_i;
      end
      if (rd_en_i) begin
        fwd_q <= fwd_hit;
      end
    end
  end

  // Stage payload
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      addr_q     <= rd_addr_i;
      pix_q      <= pix_i;
      meta_q     <= meta_i;
      fwd_data_q <= {pix_q, mid_o};
    end
  end

  assign valid_o = valid_q;
  assign pix_o   = pix_q;
  assign meta_o  = meta_q;

  // A read that collides with the write of the same edge sees the written entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_en_i && fwd_hit) |=> ({mid_o, up_o} === $past({pix_q, mid_o})))
    else $error("line store forwarding lost a same-column write");

  // An accepted pixel is held in the stage on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en_i |=> valid_q)
    else $error("accepted pixel missing from line store stage");

endmodule

@@ rtl/core/mf3_window.sv @@
// 3x3 window registers and the pipelined per-channel median network.
module mf3_window import mf3_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      valid_i,
  input  mf3_pix_t  pix_i,
  input  mf3_pix_t  up_i,
  input  mf3_pix_t  mid_i,
  input  mf3_meta_t meta_i,
  output logic      res_valid_o,
  output mf3_res_t  res_o
);

  typedef logic [2:0][CH_W-1:0] trio_t;

  function automatic logic [CH_W-1:0] min2(logic [CH_W-1:0] a, logic [CH_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [CH_W-1:0] max2(logic [CH_W-1:0] a, logic [CH_W-1:0] b);
    return (a < b) ? b : a;
  endfunction

  function automatic logic [CH_W-1:0] med3(logic [CH_W-1:0] a, logic [CH_W-1:0] b,
                                           logic [CH_W-1:0] c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  // Sorted triple, lowest in element 0
  function automatic trio_t sort3(logic [CH_W-1:0] a, logic [CH_W-1:0] b,
                                  logic [CH_W-1:0] c);
    trio_t t;
    t[0] = min2(min2(a, b), c);
    t[1] = med3(a, b, c);
    t[2] = max2(max2(a, b), c);
    return t;
  endfunction

  // Window: rows top..bottom, columns left..right, k = row*3 + col
  mf3_pix_t  win_q [9];
  logic      win_valid_q, m1_valid_q, m2_valid_q;
  mf3_meta_t win_meta_q, m1_meta_q, m2_meta_q;
  logic [CH_W-1:0] med [N_CH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 9; k++) begin
        win_q[k] <= '0;
      end
    end else if (en_i && valid_i) begin
      for (int k = 0; k < 3; k++) begin
        win_q[k*3]   <= win_q[k*3+1];
        win_q[k*3+1] <= win_q[k*3+2];
      end
      win_q[2] <= up_i;
      win_q[5] <= mid_i;
      win_q[8] <= pix_i;
    end
  end

  // Only interior pixels travel on through the median stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_valid_q <= 1'b0;
      m1_valid_q  <= 1'b0;
      m2_valid_q  <= 1'b0;
    end else if (en_i) begin
      win_valid_q <= valid_i && meta_i.emit;
      m1_valid_q  <= win_valid_q;
      m2_valid_q  <= m1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (valid_i) begin
        win_meta_q <= meta_i;
      end
      m1_meta_q <= win_meta_q;
      m2_meta_q <= m1_meta_q;
    end
  end

  // Median of nine: sort rows, then max of lows, median of mids, min of highs
  for (genvar ch = 0; ch < N_CH; ch++) begin : g_ch
    trio_t           m1_q [3];
    logic [CH_W-1:0] m2_q [3];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int r = 0; r < 3; r++) begin
          m1_q[r] <= sort3(win_q[r*3][ch*CH_W +: CH_W], win_q[r*3+1][ch*CH_W +: CH_W],
                           win_q[r*3+2][ch*CH_W +: CH_W]);
        end
        m2_q[0] <= max2(max2(m1_q[0][0], m1_q[1][0]), m1_q[2][0]);
        m2_q[1] <= med3(m1_q[0][1], m1_q[1][1], m1_q[2][1]);
        m2_q[2] <= min2(min2(m1_q[0][2], m1_q[1][2]), m1_q[2][2]);
      end
    end

    assign med[ch] = med3(m2_q[0], m2_q[1], m2_q[2]);
  end

  assign res_valid_o   = m2_valid_q;
  assign res_o.last    = m2_meta_q.last;
  assign res_o.col     = m2_meta_q.col;
  assign res_o.row     = m2_meta_q.row;
  assign res_o.med.blue  = med[0];
  assign res_o.med.green = med[1];
  assign res_o.med.red   = med[2];

  // A result always centers on an interior pixel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (res_o.row != '0) && (res_o.col != '0))
    else $error("median result centered on a border pixel");

endmodule

@@ rtl/core/median_filter_3x3_rgb.sv @@
// Top level of the streaming 3x3 RGB median filter.
//
// Pixels enter on the s_axis channel in raster order, one beat per pixel.
// For every pixel whose 3x3 neighborhood lies inside the frame, one beat
// leaves on m_axis with the per-channel median and the center row/column;
// m_axis_tlast marks the last interior pixel of the frame. Border pixels
// give no beat.
// Throughput is one pixel per clock while the receiver keeps up; a pixel's
// result passes the line memory read, window update, two median stages and
// then the output register. The frame size is set through the write port
// (index 0 width, 1 height); the user must write it only while the block
// is idle; the block does not enforce this. Reset clears the row/column
// counters and the window and loads a 640x480 frame; the line memory is
// not cleared, since a result only uses entries that the two rows above it
// have written. When the receiver stalls, the output register and a
// one-beat skid buffer absorb the pipeline; s_axis_tready drops while the
// skid buffer is full, and the whole pipeline holds until it drains.
module median_filter_3x3_rgb import mf3_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // config write port
  input  logic                   cfg_we_i,
  input  logic [IDX_W-1:0]       cfg_idx_i,
  input  logic [CFG_W-1:0]       cfg_wdata_i,
  // pixel input
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // pix_blue, pix_green, pix_red
  // result output
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // med_blue, med_green, med_red, center_row, center_col, zero pad
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                   m_axis_tlast   // frame_last
);

  logic             en, accept, push;
  logic [COL_W-1:0] rd_addr;
  mf3_meta_t        meta_in, meta_s1;
  mf3_pix_t         pix_in, pix_s1, up_s1, mid_s1;
  logic             valid_s1, res_valid;
  mf3_res_t         res;

  logic     out_valid_q, skid_valid_q;
  mf3_res_t out_q, skid_q;

  // The pipeline moves whenever the skid buffer has room
  assign en            = !skid_valid_q;
  assign s_axis_tready = en;
  assign accept        = s_axis_tvalid && en;
  assign pix_in        = mf3_pix_t'(s_axis_tdata[PIX_W-1:0]);

  mf3_raster u_raster (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .rd_addr_o   (rd_addr),
    .meta_o      (meta_in)
  );

  mf3_line_store u_line_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .rd_en_i   (accept),
    .rd_addr_i (rd_addr),
    .pix_i     (pix_in),
    .meta_i    (meta_in),
    .valid_o   (valid_s1),
    .pix_o     (pix_s1),
    .up_o      (up_s1),
    .mid_o     (mid_s1),
    .meta_o    (meta_s1)
  );

  mf3_window u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (valid_s1),
    .pix_i       (pix_s1),
    .up_i        (up_s1),
    .mid_i       (mid_s1),
    .meta_i      (meta_s1),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign push = en && res_valid;

  // Output register and skid buffer: control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_valid_q && m_axis_tready) begin
      skid_valid_q <= 1'b0;
      out_valid_q  <= skid_valid_q || push;
    end else if (push) begin
      if (out_valid_q) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end
  end

  // Output register and skid buffer: payload
  always_ff @(posedge clk_i) begin
    if (out_valid_q && m_axis_tready) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (push) begin
        out_q <= res;
      end
    end else if (push) begin
      if (out_valid_q) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'({out_q.col, out_q.row, out_q.med});
  assign m_axis_tlast  = out_q.last;

  // The skid buffer only fills behind a waiting output beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid buffer holds a beat while the output is empty");

  // A result arriving behind a stalled beat is kept, not dropped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && out_valid_q && !m_axis_tready) |=> skid_valid_q)
    else $error("result lost while output stalled");

endmodule
